@@ rtl/core/skit_pkg.sv @@
`default_nettype none
package skit_pkg;

  // Table geometry; slot and count fields of the ports are sized for it
  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyChars = 8;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned RecW     = 14;

  // Operation codes
  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOSLOT   = 2'd3;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [RecW-1:0] rec;
  } entry_t;

  // Fold A-Z to lower case, keep KeyChars characters, stop at first NUL
  function automatic logic [KeyW-1:0] canon_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic [7:0]      c;
    logic            live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      c = k[KeyW-1-8*i -: 8];
      if (c == 8'd0 || i >= KeyChars) begin
        live = 1'b0;
      end
      if (live) begin
        if (c >= 8'h41 && c <= 8'h5A) begin
          c = c + 8'h20;
        end
        r[KeyW-1-8*i -: 8] = c;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sorted_key_index_table_top.sv @@
// Channel | Dir | tuser       | tdata fields (lowest bit first)
// s       | in  | op[1:0]     | name_key[63:0] record_number[77:64] slot[83:78]
// m       | out | status[1:0] | found_slot[5:0] found_key[69:6]
//         |     |             | found_record[83:70] entry_count[90:84]
// One word at a time. Find: search steps of a memory read and a compare,
// then a read and key check. Insert: search, then a read and write per entry
// moved up. Remove: slot read, then a read and write per entry moved down.
// Reset clears the state, the output valid and the entry count; the entry memory needs no clearing.
// A result waits in the output register; no new word is taken until it is.
`default_nettype none
module sorted_key_index_table_top
  import skit_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [1:0]  s_tuser_i,   // op
  input  wire logic [87:0] s_tdata_i,   // name_key, record_number, slot
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [1:0]       m_tuser_o,   // status
  output logic [95:0]      m_tdata_o    // found_slot, found_key,
                                        // found_record, entry_count
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_FCHK = 4'd3;
  localparam logic [3:0] S_INSR = 4'd4;
  localparam logic [3:0] S_INSW = 4'd5;
  localparam logic [3:0] S_RCAP = 4'd6;
  localparam logic [3:0] S_REMR = 4'd7;
  localparam logic [3:0] S_REMW = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d, ck_q, ck_d;
  logic [RecW-1:0]   rec_q, rec_d;
  logic [AddrW-1:0]  slot_q, slot_d;
  logic [CountW-1:0] occ_q, occ_d, lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic [CountW-1:0] mid;
  entry_t            gone_q, gone_d;

  logic              ov_q, ov_d;
  logic [1:0]        o_st_q, o_st_d;
  logic [AddrW-1:0]  o_slot_q, o_slot_d;
  entry_t            o_ent_q, o_ent_d;
  logic [CountW-1:0] o_cnt_q;

  // Entry memory
  entry_t            mem [Capacity];
  entry_t            rd_q;
  logic              re, we;
  logic [AddrW-1:0]  ra, wa;
  entry_t            wd;

  logic              accept, emit;
  logic              below;

  assign s_tready_o = (state_q == S_IDLE) && !ov_q;
  assign accept     = s_tvalid_i && s_tready_o;
  assign mid        = CountW'((lo_q + hi_q) >> 1);
  assign below      = (op_q == OP_INS) ? (canon_key(rd_q.key) <= ck_q)
                                       : (canon_key(rd_q.key) <  ck_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    ck_d     = ck_q;
    rec_d    = rec_q;
    slot_d   = slot_q;
    occ_d    = occ_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    gone_d   = gone_q;
    ov_d     = ov_q && !m_tready_i;
    o_st_d   = o_st_q;
    o_slot_d = o_slot_q;
    o_ent_d  = o_ent_q;
    emit     = 1'b0;
    re       = 1'b0;
    ra       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = rd_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = s_tuser_i;
          key_d  = s_tdata_i[63:0];
          ck_d   = canon_key(s_tdata_i[63:0]);
          rec_d  = s_tdata_i[77:64];
          slot_d = s_tdata_i[83:78];
          lo_d   = '0;
          hi_d   = occ_q;
          emit   = 1'b1;
          o_st_d = ST_OK;
          o_slot_d = '0;
          o_ent_d  = '0;
          case (s_tuser_i)
            OP_INS: begin
              if (occ_q == CountW'(Capacity)) begin
                o_st_d = ST_FULL;
              end else begin
                emit    = 1'b0;
                state_d = S_SRCH;
              end
            end
            OP_FIND: begin
              emit    = 1'b0;
              state_d = S_SRCH;
            end
            OP_REM: begin
              if (CountW'(s_tdata_i[83:78]) >= occ_q) begin
                o_st_d = ST_NOSLOT;
              end else begin
                emit    = 1'b0;
                re      = 1'b1;
                ra      = s_tdata_i[83:78];
                state_d = S_RCAP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          re      = 1'b1;
          ra      = mid[AddrW-1:0];
          state_d = S_SCMP;
        end else if (op_q == OP_INS) begin
          idx_d   = occ_q;
          state_d = S_INSR;
        end else if (lo_q < occ_q) begin
          re      = 1'b1;
          ra      = lo_q[AddrW-1:0];
          state_d = S_FCHK;
        end else begin
          emit     = 1'b1;
          o_st_d   = ST_NOTFOUND;
          o_slot_d = '0;
          o_ent_d  = '0;
          state_d  = S_IDLE;
        end
      end
      S_SCMP: begin
        if (below) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = S_SRCH;
      end
      S_FCHK: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (canon_key(rd_q.key) == ck_q) begin
          o_st_d   = ST_OK;
          o_slot_d = lo_q[AddrW-1:0];
          o_ent_d  = rd_q;
        end else begin
          o_st_d   = ST_NOTFOUND;
          o_slot_d = '0;
          o_ent_d  = '0;
        end
      end
      // Move entries up one slot, top first, then drop the new one in
      S_INSR: begin
        if (idx_q > lo_q) begin
          re      = 1'b1;
          ra      = AddrW'(idx_q - 1'b1);
          state_d = S_INSW;
        end else begin
          we       = 1'b1;
          wa       = lo_q[AddrW-1:0];
          wd       = '{key: key_q, rec: rec_q};
          occ_d    = occ_q + 1'b1;
          emit     = 1'b1;
          o_st_d   = ST_OK;
          o_slot_d = lo_q[AddrW-1:0];
          o_ent_d  = '{key: key_q, rec: rec_q};
          state_d  = S_IDLE;
        end
      end
      S_INSW: begin
        we      = 1'b1;
        wa      = idx_q[AddrW-1:0];
        idx_d   = idx_q - 1'b1;
        state_d = S_INSR;
      end
      S_RCAP: begin
        gone_d  = rd_q;
        idx_d   = CountW'(slot_q);
        state_d = S_REMR;
      end
      // Move entries down one slot to close the gap
      S_REMR: begin
        if (idx_q + 1'b1 < occ_q) begin
          re      = 1'b1;
          ra      = AddrW'(idx_q + 1'b1);
          state_d = S_REMW;
        end else begin
          occ_d    = occ_q - 1'b1;
          emit     = 1'b1;
          o_st_d   = ST_OK;
          o_slot_d = slot_q;
          o_ent_d  = gone_q;
          state_d  = S_IDLE;
        end
      end
      S_REMW: begin
        we      = 1'b1;
        wa      = idx_q[AddrW-1:0];
        idx_d   = idx_q + 1'b1;
        state_d = S_REMR;
      end
      default: state_d = S_IDLE;
    endcase
    if (emit) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    ck_q     <= ck_d;
    rec_q    <= rec_d;
    slot_q   <= slot_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    idx_q    <= idx_d;
    gone_q   <= gone_d;
    o_st_q   <= o_st_d;
    o_slot_q <= o_slot_d;
    o_ent_q  <= o_ent_d;
    if (emit) begin
      o_cnt_q <= occ_d;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tuser_o  = o_st_q;
  assign m_tdata_o  = {5'b00000, o_cnt_q, o_ent_q.rec, o_ent_q.key, o_slot_q};

  // Checks
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CountW'(Capacity))
    else $error("entry count above capacity");

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ov_q)
    else $error("result pending while busy");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> $rose(ov_q))
    else $error("entry count changed without a result");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCMP) |-> (lo_q < hi_q && hi_q <= occ_q))
    else $error("search window out of range");

endmodule
`default_nettype wire

@@ sim/sorted_key_index_table_top_tb.sv @@
`default_nettype none
module sorted_key_index_table_top_tb;
  import skit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [63:0] key;
    logic [13:0] rec;
    logic [6:0]  count;
  } lookup_t;

  // Scoreboard: shadow copy of the sorted table and the pending results
  class index_board;
    logic [63:0] keys[64];
    logic [13:0] recs[64];
    int unsigned used;
    lookup_t     pending[$];
    int          errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // Case-folded key prefix up to the first NUL; unsigned order is string order
    function logic [63:0] fold(logic [63:0] k);
      logic [63:0] r;
      logic [7:0]  c;
      r = '0;
      for (int i = 0; i < 8 && i < KeyChars; i++) begin
        c = k[63-8*i -: 8];
        if (c == 8'd0) break;
        if (c >= "A" && c <= "Z") c = c + 8'h20;
        r[63-8*i -: 8] = c;
      end
      return r;
    endfunction

    // Apply one accepted word to the shadow table and queue its result
    function void note_word(logic [1:0] op, logic [63:0] key, logic [13:0] rec,
                            logic [5:0] slot);
      lookup_t     res;
      logic [63:0] ck;
      int unsigned pos;
      res = '0;
      ck  = fold(key);
      pos = 0;
      case (op)
        OP_INS: begin
          if (used >= Capacity) begin
            res.status = ST_FULL;
          end else begin
            while (pos < used && fold(keys[pos]) <= ck) pos++;
            for (int i = used; i > pos; i--) begin
              keys[i] = keys[i-1];
              recs[i] = recs[i-1];
            end
            keys[pos] = key;
            recs[pos] = rec;
            used++;
            res.status = ST_OK;
            res.slot   = 6'(pos);
            res.key    = key;
            res.rec    = rec;
          end
        end
        OP_FIND: begin
          while (pos < used && fold(keys[pos]) < ck) pos++;
          if (pos < used && fold(keys[pos]) == ck) begin
            res.status = ST_OK;
            res.slot   = 6'(pos);
            res.key    = keys[pos];
            res.rec    = recs[pos];
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        OP_REM: begin
          if (slot >= used) begin
            res.status = ST_NOSLOT;
          end else begin
            res.status = ST_OK;
            res.slot   = slot;
            res.key    = keys[slot];
            res.rec    = recs[slot];
            for (int i = slot; i + 1 < used; i++) begin
              keys[i] = keys[i+1];
              recs[i] = recs[i+1];
            end
            used--;
          end
        end
        default: res.status = ST_OK;
      endcase
      res.count = 7'(used);
      pending.push_back(res);
    endfunction

    // Compare one result word against the oldest pending result
    function void check_word(logic [1:0] status, logic [95:0] data);
      lookup_t got;
      lookup_t want;
      got.status = status;
      got.slot   = data[5:0];
      got.key    = data[69:6];
      got.rec    = data[83:70];
      got.count  = data[90:84];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h/%h", status, data);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: status %0d/%0d slot %0d/%0d key %h/%h",
                    " rec %0d/%0d cnt %0d/%0d"},
                   want.status, got.status, want.slot, got.slot, want.key, got.key,
                   want.rec, got.rec, want.count, got.count);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [1:0]  s_tuser_i;
  logic [87:0] s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [1:0]  m_tuser_o;
  logic [95:0] m_tdata_o;

  index_board  board;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  logic [63:0] name_pool[16];

  sorted_key_index_table_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tuser_o  (m_tuser_o),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stall, check each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) board.check_word(m_tuser_o, m_tdata_o);
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one word and hold it until accepted; random gap before it
  task automatic send_word(logic [1:0] op, logic [63:0] key, logic [13:0] rec,
                           logic [5:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {4'b0, slot, rec, key};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    board.note_word(op, key, rec, slot);
  endtask

  // Random name: mixed case letters, sometimes short, sometimes garbage after NUL
  function automatic logic [63:0] rand_name();
    logic [63:0] k;
    int          len;
    k   = {$urandom, $urandom};
    len = $urandom_range(8);
    for (int i = 0; i < 8; i++) begin
      if (i < len) begin
        k[63-8*i -: 8] = 8'(($urandom_range(1) ? "A" : "a") + $urandom_range(25));
      end else if (i == len || $urandom_range(3) != 0) begin
        k[63-8*i -: 8] = 8'd0;
      end
    end
    return k;
  endfunction

  // Pick a pooled name, with its case randomly flipped to hit equal keys
  function automatic logic [63:0] pool_name();
    logic [63:0] k;
    logic [7:0]  c;
    k = name_pool[$urandom_range(15)];
    for (int i = 0; i < 8; i++) begin
      c = k[8*i +: 8];
      if ($urandom_range(1) && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
        k[8*i +: 8] = c ^ 8'h20;
    end
    return k;
  endfunction

  task automatic random_phase(int n);
    logic [1:0]  op;
    logic [63:0] key;
    int          sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      key = ($urandom_range(2) == 0) ? rand_name() : pool_name();
      // bias ops by fill level so the table swings between empty and full
      if (sel < 3) op = OP_NOP;
      else if (sel < (board.used < 40 ? 50 : 30)) op = OP_INS;
      else if (sel < 70) op = OP_FIND;
      else op = OP_REM;
      send_word(op, key, 14'($urandom_range(9999)),
                6'(($urandom_range(3) == 0) ? $urandom_range(63)
                   : $urandom_range(board.used > 0 ? board.used - 1 : 0)));
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    s_tvalid_i    = 1'b0;
    s_tuser_i     = '0;
    s_tdata_i     = '0;
    m_tready_i    = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 36;
    recv_idle_pct = 55;
    for (int i = 0; i < 16; i++) name_pool[i] = rand_name();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table cases, extremes, equal keys, op 3
    send_word(OP_FIND, 64'h0, 0, 0);
    send_word(OP_REM, 64'h0, 0, 0);
    send_word(OP_NOP, '1, 14'h3FFF, 6'h3F);
    send_word(OP_INS, {"Alpha", 24'h0}, 9999, 63);
    send_word(OP_INS, {"ALPHA", 24'h0}, 1, 0);
    send_word(OP_INS, 64'h0, 0, 0);
    send_word(OP_INS, '1, 14'h3FFF, 0);
    send_word(OP_INS, {"zz", 8'h00, "garb", 8'h00}, 5, 0);
    send_word(OP_FIND, {"alpha", 24'h0}, 0, 0);
    send_word(OP_FIND, {"ZZ", 48'hFFFF_FFFF_FF00}, 0, 0);
    send_word(OP_FIND, {"beta", 32'h0}, 0, 0);
    send_word(OP_REM, 64'h0, 0, 6'h3F);
    send_word(OP_REM, 64'h0, 0, 1);
    send_word(OP_FIND, {"alpha", 24'h0}, 0, 0);
    send_word(OP_REM, 64'h0, 0, 0);
    // Fill to capacity, overflow, then free the top slot and insert twice
    for (int i = 0; i < 66; i++) send_word(OP_INS, rand_name(), 14'($urandom_range(9999)), 0);
    send_word(OP_REM, 64'h0, 0, 63);
    send_word(OP_INS, '0, 0, 0);
    send_word(OP_INS, '1, 0, 0);
    drain();

    random_phase(350);
    drain();
    send_idle_pct = 55;
    recv_idle_pct = 36;
    random_phase(350);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(250);
    drain();
    repeat (300) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
